### sv/sila_pkg.sv
`timescale 1ns / 1ps
package sila_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 5;
  localparam int unsigned REL_W  = 3;
  localparam int unsigned LANES  = 4;

  // opcodes
  localparam logic [OP_W-1:0] OP_NEG    = 5'd0;
  localparam logic [OP_W-1:0] OP_NOT    = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL    = 5'd4;
  localparam logic [OP_W-1:0] OP_DIVU   = 5'd5;
  localparam logic [OP_W-1:0] OP_REMU   = 5'd6;
  localparam logic [OP_W-1:0] OP_DIVS   = 5'd7;
  localparam logic [OP_W-1:0] OP_REMS   = 5'd8;
  localparam logic [OP_W-1:0] OP_AND    = 5'd9;
  localparam logic [OP_W-1:0] OP_OR     = 5'd10;
  localparam logic [OP_W-1:0] OP_XOR    = 5'd11;
  localparam logic [OP_W-1:0] OP_EQMASK = 5'd12;
  localparam logic [OP_W-1:0] OP_SHL    = 5'd13;
  localparam logic [OP_W-1:0] OP_SHRU   = 5'd14;
  localparam logic [OP_W-1:0] OP_SHRS   = 5'd15;
  localparam logic [OP_W-1:0] OP_CMPU   = 5'd16;
  localparam logic [OP_W-1:0] OP_CMPS   = 5'd17;

  // relations
  localparam logic [REL_W-1:0] REL_LT = 3'd0;
  localparam logic [REL_W-1:0] REL_LE = 3'd1;
  localparam logic [REL_W-1:0] REL_GT = 3'd2;
  localparam logic [REL_W-1:0] REL_GE = 3'd3;
  localparam logic [REL_W-1:0] REL_EQ = 3'd4;
  localparam logic [REL_W-1:0] REL_NE = 3'd5;

  localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

  typedef logic [WORD_W-1:0] word_t;

  // control for each lane, decoded at the pipe entry
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REL_W-1:0] relation;
  } ctl_t;

  // one request: opcode, relation and both operand vectors
  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [REL_W-1:0]             relation;
    logic [LANES-1:0][WORD_W-1:0] a;
    logic [LANES-1:0][WORD_W-1:0] b;
  } req_t;

  // one result: a word per lane
  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0] result;
  } res_t;

endpackage

### sv/simd_integer_lane_alu.sv
`timescale 1ns / 1ps
// path: entry register (loads when a request is accepted), then 32 divide
// stages, then the output register;
// every op takes the same path
// throughput: one request per cycle; the pipe stalls as a whole on out_stall while out_valid is high
// reset: synchronous active-low rst_n clears the valid bits of the pipe
module simd_integer_lane_alu
  import sila_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  localparam int unsigned DEPTH = WORD_W + 1;

  // whole pipe moves when the output is free
  logic adv;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  ctl_t ctl;
  word_t lane_res [LANES];
  res_t out_data_r;

  assign adv = ~out_stall | ~out_valid;
  assign in_stall = ~adv;
  assign ctl = '{op: in_data.op, relation: in_data.relation};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sila_lane u_lane (
      .clk(clk), .adv(adv), .ctl(ctl), .a(in_data.a[i]), .b(in_data.b[i]),
      .result(lane_res[i])
    );
  end

  // output register, all lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) out_data_r.result[i] <= lane_res[i];
    end
  end

  assign out_data = out_data_r;

  // valid shift
  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_valid};
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/sila_lane.sv
`timescale 1ns / 1ps
// one lane: simple ops done at entry, divider pipelined one quotient bit a stage
module sila_lane
  import sila_pkg::*;
(
  input  logic  clk,
  input  logic  adv,
  input  ctl_t  ctl,
  input  word_t a,
  input  word_t b,
  output word_t result
);

  // entry decode
  word_t            simple;
  logic             use_div;
  logic             is_rem;
  logic             neg_q;
  logic             neg_r;
  logic             zero_res;
  word_t            dvd;
  word_t            dvs;
  logic             lt_u;
  logic             eq;
  logic             t;
  logic             rel_ok;
  logic [4:0]       sh;
  word_t            ax;
  word_t            bx;

  always_comb begin
    sh = b[4:0];
    ax = (ctl.op == OP_CMPS) ? (a ^ SIGN_BIT) : a;
    bx = (ctl.op == OP_CMPS) ? (b ^ SIGN_BIT) : b;
    lt_u = ax < bx;
    eq = ax == bx;
    rel_ok = 1'b1;
    case (ctl.relation)
      REL_LT: t = lt_u;
      REL_LE: t = lt_u | eq;
      REL_GT: t = ~(lt_u | eq);
      REL_GE: t = ~lt_u;
      REL_EQ: t = eq;
      REL_NE: t = ~eq;
      default: begin
        t = 1'b0;
        rel_ok = 1'b0;
      end
    endcase
    case (ctl.op)
      OP_NEG:    simple = word_t'(0) - a;
      OP_NOT:    simple = ~a;
      OP_ADD:    simple = a + b;
      OP_SUB:    simple = a - b;
      OP_MUL:    simple = a * b;
      OP_AND:    simple = a & b;
      OP_OR:     simple = a | b;
      OP_XOR:    simple = a ^ b;
      OP_EQMASK: simple = ~(a ^ b);
      OP_SHL:    simple = a << sh;
      OP_SHRU:   simple = a >> sh;
      OP_SHRS:   simple = word_t'($signed(a) >>> sh);
      OP_CMPU, OP_CMPS: simple = (rel_ok && t) ? '1 : '0;
      default:   simple = '0;
    endcase
    use_div = (ctl.op inside {OP_DIVU, OP_REMU, OP_DIVS, OP_REMS});
    is_rem = (ctl.op inside {OP_REMU, OP_REMS});
    zero_res = (b == '0);
    if (ctl.op inside {OP_DIVS, OP_REMS}) begin
      dvd = a[WORD_W-1] ? (word_t'(0) - a) : a;
      dvs = b[WORD_W-1] ? (word_t'(0) - b) : b;
      neg_q = a[WORD_W-1] ^ b[WORD_W-1];
      neg_r = a[WORD_W-1];
    end else begin
      dvd = a;
      dvs = b;
      neg_q = 1'b0;
      neg_r = 1'b0;
    end
  end

  // divider pipe: stage k resolves quotient bit WORD_W-1-k
  word_t rem_r  [WORD_W+1];
  word_t quo_r  [WORD_W+1];
  word_t dvs_r  [WORD_W+1];
  word_t smp_r  [WORD_W+1];
  logic  div_r  [WORD_W+1];
  logic  rm_r   [WORD_W+1];
  logic  nq_r   [WORD_W+1];
  logic  nr_r   [WORD_W+1];
  logic  z_r    [WORD_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      quo_r[0] <= dvd;
      dvs_r[0] <= dvs;
      smp_r[0] <= simple;
      div_r[0] <= use_div;
      rm_r[0]  <= is_rem;
      nq_r[0]  <= neg_q;
      nr_r[0]  <= neg_r;
      z_r[0]   <= zero_res;
    end
  end

  for (genvar k = 0; k < WORD_W; k++) begin : g_div
    logic [WORD_W:0] trial;
    logic [WORD_W:0] sub;
    always_comb begin
      trial = {rem_r[k], quo_r[k][WORD_W-1]};
      sub = trial - {1'b0, dvs_r[k]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= sub[WORD_W] ? trial[WORD_W-1:0] : sub[WORD_W-1:0];
        quo_r[k+1] <= {quo_r[k][WORD_W-2:0], ~sub[WORD_W]};
        dvs_r[k+1] <= dvs_r[k];
        smp_r[k+1] <= smp_r[k];
        div_r[k+1] <= div_r[k];
        rm_r[k+1]  <= rm_r[k];
        nq_r[k+1]  <= nq_r[k];
        nr_r[k+1]  <= nr_r[k];
        z_r[k+1]   <= z_r[k];
      end
    end
  end

  // sign fix and select
  word_t fin;
  always_comb begin
    if (!div_r[WORD_W]) begin
      fin = smp_r[WORD_W];
    end else if (z_r[WORD_W]) begin
      fin = '0;
    end else if (rm_r[WORD_W]) begin
      fin = nr_r[WORD_W] ? (word_t'(0) - rem_r[WORD_W]) : rem_r[WORD_W];
    end else begin
      fin = nq_r[WORD_W] ? (word_t'(0) - quo_r[WORD_W]) : quo_r[WORD_W];
    end
  end

  assign result = fin;

endmodule

### test/simd_integer_lane_alu_tb.sv
`timescale 1ns / 1ps
module simd_integer_lane_alu_tb
  import sila_pkg::*;
();

  localparam int LATENCY = 33;

  typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;

  vec_t lane_results_q[$];
  int errors;
  bit rx_idle_en;
  int rx_hold;

  simd_integer_lane_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // relation evaluated on two words
  function automatic word_t relate(word_t a, word_t b, logic [REL_W-1:0] rel);
    logic t;
    case (rel)
      REL_LT: t = a < b;
      REL_LE: t = a <= b;
      REL_GT: t = a > b;
      REL_GE: t = a >= b;
      REL_EQ: t = a == b;
      REL_NE: t = a != b;
      default: return '0;
    endcase
    return t ? '1 : '0;
  endfunction

  function automatic word_t magnitude(word_t v);
    return v[31] ? -v : v;
  endfunction

  // one lane of the alu
  function automatic word_t lane_value(logic [OP_W-1:0] op, logic [REL_W-1:0] rel,
                                       word_t a, word_t b);
    word_t q;
    logic [4:0] sh;
    sh = b[4:0];
    case (op)
      OP_NEG: return -a;
      OP_NOT: return ~a;
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIVU: return (b == 0) ? '0 : a / b;
      OP_REMU: return (b == 0) ? '0 : a % b;
      OP_DIVS: begin
        if (b == 0) return '0;
        q = magnitude(a) / magnitude(b);
        return (a[31] ^ b[31]) ? -q : q;
      end
      OP_REMS: begin
        if (b == 0) return '0;
        q = magnitude(a) % magnitude(b);
        return a[31] ? -q : q;
      end
      OP_AND: return a & b;
      OP_OR: return a | b;
      OP_XOR: return a ^ b;
      OP_EQMASK: return ~(a ^ b);
      OP_SHL: return a << sh;
      OP_SHRU: return a >> sh;
      OP_SHRS: return word_t'($signed(a) >>> sh);
      OP_CMPU: return relate(a, b, rel);
      OP_CMPS: return relate(a ^ SIGN_BIT, b ^ SIGN_BIT, rel);
      default: return '0;
    endcase
  endfunction

  // random word biased toward edge values
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SIGN_BIT;
      3: return 32'h7fff_ffff;
      4: return word_t'($urandom_range(0, 40));
      5: return -word_t'($urandom_range(1, 40));
      default: return $urandom;
    endcase
  endfunction

  // send one request and record the expected lanes
  task automatic send_request(logic [OP_W-1:0] op, logic [REL_W-1:0] rel,
                              vec_t a, vec_t b, bit gaps);
    vec_t res;
    req_t req;
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < LANES; i++) res[i] = lane_value(op, rel, a[i], b[i]);
    req.op = op;
    req.relation = rel;
    req.a = a;
    req.b = b;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lane_results_q.push_back(res);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  task automatic random_request(bit gaps);
    vec_t a, b;
    for (int i = 0; i < LANES; i++) begin
      a[i] = pick_word();
      b[i] = pick_word();
    end
    send_request(5'($urandom_range(0, 19) == 0 ? $urandom_range(18, 31)
                                             : $urandom_range(0, 17)),
                 3'($urandom_range(0, 7)), a, b, gaps);
  endtask

  task automatic wait_drained();
    while (lane_results_q.size() != 0) @(posedge clk);
  endtask

  // every op and relation code on edge operands, plus the division corner cases
  task automatic test_directed();
    vec_t a, b;
    a = {32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0000};
    b = {32'hffff_ffff, 32'h0000_0000, 32'h0000_0021, 32'h8000_0000};
    for (int op = 0; op <= 17; op++) send_request(5'(op), REL_LT, a, b, 0);
    for (int rel = 0; rel <= 7; rel++) begin
      send_request(OP_CMPU, 3'(rel), a, {b[3:1], 32'h0}, 0);
      send_request(OP_CMPS, 3'(rel), a, b, 0);
    end
    send_request(5'd31, 3'd7, '1, '1, 0);
    send_request(OP_DIVS, REL_LT, {4{32'h8000_0000}},
                 {32'hffff_ffff, 32'h0, 32'hffff_fff9, 32'h7}, 0);
    send_request(OP_REMS, REL_LT, {32'h8000_0000, 32'hffff_fff9, 32'h7, 32'h8000_0000},
                 {32'hffff_ffff, 32'h2, 32'hffff_fffe, 32'h0}, 0);
    go_idle();
  endtask

  // long receiver hold while requests keep coming, then a full drain pause
  task automatic test_backpressure();
    rx_hold = 3 * LATENCY;
    for (int i = 0; i < 60; i++) random_request(0);
    go_idle();
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 380; i++) random_request(1);
    rx_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) random_request(0);
    go_idle();
  endtask

  // receiver: random stall bursts, or a counted long hold
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (lane_results_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data.result);
        errors++;
      end else begin
        exp_v = lane_results_q.pop_front();
        for (int i = 0; i < LANES; i++)
          if (out_data.result[i] !== exp_v[i]) begin
            $display("%0t: lane %0d expected %h actual %h", $time, i, exp_v[i],
                     out_data.result[i]);
            errors++;
          end
      end
    end
  end

  initial begin
    errors = 0;
    rx_idle_en = 1'b1;
    rx_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && lane_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
sv/sila_pkg.sv
sv/sila_lane.sv
sv/simd_integer_lane_alu.sv
test/simd_integer_lane_alu_tb.sv
